### design/pcrr_pkg.sv
// Shared types and constants for the per-core round-robin scheduler.
// No dependencies; every other design file refers to it by scoped names.
package pcrr_pkg;

    localparam int MAX_CORES   = 4;
    localparam int CORE_W      = 2;
    localparam int QUEUE_DEPTH = 16;
    localparam int QPTR_W      = 4;
    localparam int QCNT_W      = 5;
    localparam int BLK_DEPTH   = 16;
    localparam int BLK_IDX_W   = 4;
    localparam int BLK_CNT_W   = 5;
    localparam int TASK_W      = 8;
    localparam int LOAD_W      = 6;
    localparam int QSTORE_AW   = CORE_W + QPTR_W;
    localparam int SLICE_W     = 8;
    localparam int AC_W        = 3;
    localparam int PADDR_W     = 5;

    localparam logic [1:0] FUNC_LOAD    = 2'd0;
    localparam logic [1:0] FUNC_UNBLOCK = 2'd1;
    localparam logic [1:0] FUNC_EVENT   = 2'd2;

    localparam logic [1:0] RSN_TICK  = 2'd0;
    localparam logic [1:0] RSN_BLOCK = 2'd1;
    localparam logic [1:0] RSN_EXIT  = 2'd2;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_QFULL     = 2'd1;
    localparam logic [1:0] STAT_NOT_BLK   = 2'd2;
    localparam logic [1:0] STAT_BLK_FULL  = 2'd3;

    localparam logic [2:0] REG_ACTIVE = 3'd0;
    localparam logic [2:0] REG_QUANT0 = 3'd1;
    localparam logic [2:0] REG_QUANT1 = 3'd2;
    localparam logic [2:0] REG_QUANT2 = 3'd3;
    localparam logic [2:0] REG_QUANT3 = 3'd4;

    typedef struct packed {
        logic                 ins;
        logic                 rem;
        logic [BLK_IDX_W-1:0] idx;
        logic [CORE_W-1:0]    ins_core;
        logic [TASK_W-1:0]    ins_task;
    } blk_ctrl_t;

    typedef struct packed {
        logic [BLK_CNT_W-1:0] fill;
        logic                 full;
        logic [CORE_W-1:0]    rd_core;
        logic [TASK_W-1:0]    rd_task;
    } blk_stat_t;

endpackage

### design/pcrr_queue_ram.sv
// Ready queue storage: one region of slots per core, registered read.
// Depends on pcrr_pkg for widths.
module pcrr_queue_ram (
    input  logic                            clk,
    input  logic                            we,
    input  logic [pcrr_pkg::QSTORE_AW-1:0]  waddr,
    input  logic [pcrr_pkg::TASK_W-1:0]     wdata,
    input  logic                            re,
    input  logic [pcrr_pkg::QSTORE_AW-1:0]  raddr,
    output logic [pcrr_pkg::TASK_W-1:0]     rdata
);

    logic [pcrr_pkg::TASK_W-1:0] mem [pcrr_pkg::MAX_CORES*pcrr_pkg::QUEUE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### design/pcrr_blocked_table.sv
// Blocked task table, packed from entry 0 in blocking order.
// Depends on pcrr_pkg for the control and status structs.
module pcrr_blocked_table (
    input  logic                clk,
    input  logic                rst_n,
    input  pcrr_pkg::blk_ctrl_t ctrl,
    output pcrr_pkg::blk_stat_t stat
);

    logic [pcrr_pkg::CORE_W-1:0]    core_reg [pcrr_pkg::BLK_DEPTH];
    logic [pcrr_pkg::TASK_W-1:0]    task_reg [pcrr_pkg::BLK_DEPTH];
    logic [pcrr_pkg::BLK_CNT_W-1:0] fill_reg;

    // Fill count stands in for the valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (ctrl.ins)
        begin
            fill_reg <= fill_reg + 1'b1;
        end
        else if (ctrl.rem)
        begin
            fill_reg <= fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < pcrr_pkg::BLK_DEPTH; i++)
        begin
            if (ctrl.ins && fill_reg[pcrr_pkg::BLK_IDX_W-1:0] == i[pcrr_pkg::BLK_IDX_W-1:0])
            begin
                core_reg[i] <= ctrl.ins_core;
                task_reg[i] <= ctrl.ins_task;
            end
            else if (ctrl.rem && i < pcrr_pkg::BLK_DEPTH - 1
                     && i[pcrr_pkg::BLK_IDX_W-1:0] >= ctrl.idx)
            begin
                // Close the gap: pull the younger entry down.
                core_reg[i] <= core_reg[(i + 1) % pcrr_pkg::BLK_DEPTH];
                task_reg[i] <= task_reg[(i + 1) % pcrr_pkg::BLK_DEPTH];
            end
        end
    end

    assign stat.fill    = fill_reg;
    assign stat.full    = (fill_reg == pcrr_pkg::BLK_CNT_W'(pcrr_pkg::BLK_DEPTH));
    assign stat.rd_core = core_reg[ctrl.idx];
    assign stat.rd_task = task_reg[ctrl.idx];

endmodule

### design/per_core_round_robin_scheduler.sv
// Top level of the per-core round-robin scheduler: sequencer, per-core state, APB.
// Depends on pcrr_pkg, pcrr_queue_ram and pcrr_blocked_table.
//
// A command transfer is taken when start is high and busy is low; busy then
// stays high until the result has been shown. Each result appears on core,
// next_task, next_is_idle and status for exactly one cycle with done high,
// and the receiver cannot stall it, so sample it on that cycle. A load scans
// active_cores cores, with active_cores clamped to 1..4 (one core's load
// is compared per cycle by the shared add/compare unit); an unblock
// compares one blocked entry per cycle; a core event reads the ready queue
// through its memory port, which gives one registered read per pop; an
// unknown function goes straight to its result. Configuration registers
// sit at byte addresses 0 (active_cores) and 4, 8, 12, 16 (quanta); write
// them only while busy is low.
module per_core_round_robin_scheduler (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     func,
    input  logic [1:0]                     cpu,
    input  logic [1:0]                     reason,
    input  logic [pcrr_pkg::TASK_W-1:0]    task_id,
    output logic                           done,
    output logic [pcrr_pkg::CORE_W-1:0]    core,
    output logic [pcrr_pkg::TASK_W-1:0]    next_task,
    output logic                           next_is_idle,
    output logic [1:0]                     status,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pcrr_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    typedef enum logic [13:0] {
        ST_IDLE     = 14'b00000000000001,
        ST_LSCAN    = 14'b00000000000010,
        ST_LDEC     = 14'b00000000000100,
        ST_PUSH     = 14'b00000000001000,
        ST_SRCH     = 14'b00000000010000,
        ST_UCORE    = 14'b00000000100000,
        ST_UDEC     = 14'b00000001000000,
        ST_EVENT    = 14'b00000010000000,
        ST_SWITCH   = 14'b00000100000000,
        ST_POPWAIT  = 14'b00001000000000,
        ST_ROTRD    = 14'b00010000000000,
        ST_ROTWAIT  = 14'b00100000000000,
        ST_EVRES    = 14'b01000000000000,
        ST_RESP     = 14'b10000000000000
    } state_t;

    localparam int NC = pcrr_pkg::MAX_CORES;

    state_t state_reg, state_next;

    // Configuration
    logic [pcrr_pkg::AC_W-1:0]    active_reg;
    logic [pcrr_pkg::SLICE_W-1:0] quant_reg [NC];

    // Per-core state
    logic [pcrr_pkg::QPTR_W-1:0]    head_reg [NC], head_next [NC];
    logic [pcrr_pkg::QPTR_W-1:0]    tail_reg [NC], tail_next [NC];
    logic [pcrr_pkg::QCNT_W-1:0]    qcnt_reg [NC], qcnt_next [NC];
    logic [pcrr_pkg::SLICE_W-1:0]   slice_reg [NC], slice_next [NC];
    logic [pcrr_pkg::TASK_W-1:0]    run_reg [NC], run_next [NC];
    logic                           idle_reg [NC], idle_next [NC];
    logic [pcrr_pkg::BLK_CNT_W-1:0] bcnt_reg [NC], bcnt_next [NC];

    // Latched command and working registers
    logic [1:0]                     func_reg, reason_reg;
    logic [pcrr_pkg::TASK_W-1:0]    task_reg, task_next;
    logic [pcrr_pkg::CORE_W-1:0]    cur_reg, cur_next;
    logic [pcrr_pkg::BLK_CNT_W-1:0] idx_reg, idx_next;
    logic [pcrr_pkg::LOAD_W-1:0]    best_ld_reg, best_ld_next;

    // Result registers
    logic [pcrr_pkg::CORE_W-1:0]    rcore_reg, rcore_next;
    logic [pcrr_pkg::TASK_W-1:0]    rtask_reg, rtask_next;
    logic                           ridle_reg, ridle_next;
    logic [1:0]                     rstat_reg, rstat_next;

    // Shared select, load unit, memory and table hooks
    logic [pcrr_pkg::CORE_W-1:0]    sel;
    logic [pcrr_pkg::LOAD_W-1:0]    ld;
    logic [pcrr_pkg::CORE_W-1:0]    last_core;
    logic                           q_full, q_empty;
    logic                           mem_we, mem_re;
    logic [pcrr_pkg::QSTORE_AW-1:0] mem_waddr, mem_raddr;
    logic [pcrr_pkg::TASK_W-1:0]    mem_wdata, mem_rdata;
    pcrr_pkg::blk_ctrl_t            bctrl;
    pcrr_pkg::blk_stat_t            bstat;
    logic [pcrr_pkg::SLICE_W-1:0]   slice_inc;
    logic                           cfg_wr;

    pcrr_queue_ram u_qram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    pcrr_blocked_table u_blk (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (bctrl),
        .stat  (bstat)
    );

    // APB: always ready, write on the access cycle.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        prdata = '0;
        unique case (paddr[4:2])
            pcrr_pkg::REG_ACTIVE: prdata = 32'(active_reg);
            pcrr_pkg::REG_QUANT0: prdata = 32'(quant_reg[0]);
            pcrr_pkg::REG_QUANT1: prdata = 32'(quant_reg[1]);
            pcrr_pkg::REG_QUANT2: prdata = 32'(quant_reg[2]);
            pcrr_pkg::REG_QUANT3: prdata = 32'(quant_reg[3]);
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= pcrr_pkg::AC_W'(4);
            for (int i = 0; i < NC; i++)
            begin
                quant_reg[i] <= pcrr_pkg::SLICE_W'(4);
            end
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                pcrr_pkg::REG_ACTIVE: active_reg   <= pwdata[pcrr_pkg::AC_W-1:0];
                pcrr_pkg::REG_QUANT0: quant_reg[0] <= pwdata[7:0];
                pcrr_pkg::REG_QUANT1: quant_reg[1] <= pwdata[7:0];
                pcrr_pkg::REG_QUANT2: quant_reg[2] <= pwdata[7:0];
                pcrr_pkg::REG_QUANT3: quant_reg[3] <= pwdata[7:0];
                default:              ;
            endcase
        end
    end

    // Last core the load scan visits: active_cores clamped to 1..MAX_CORES, minus one.
    always_comb
    begin
        if (active_reg == '0)
        begin
            last_core = '0;
        end
        else if (active_reg >= pcrr_pkg::AC_W'(NC))
        begin
            last_core = pcrr_pkg::CORE_W'(NC - 1);
        end
        else
        begin
            last_core = pcrr_pkg::CORE_W'(active_reg - 1'b1);
        end
    end

    // One per-core read port: the scan walks cores, every other step uses cur_reg.
    assign sel       = (state_reg == ST_LSCAN) ? idx_reg[pcrr_pkg::CORE_W-1:0] : cur_reg;
    assign ld        = pcrr_pkg::LOAD_W'(qcnt_reg[sel])
                     + pcrr_pkg::LOAD_W'(!idle_reg[sel])
                     + pcrr_pkg::LOAD_W'(bcnt_reg[sel]);
    assign q_full    = (qcnt_reg[sel] >= pcrr_pkg::QCNT_W'(pcrr_pkg::QUEUE_DEPTH));
    assign q_empty   = (qcnt_reg[sel] == '0);
    assign slice_inc = slice_reg[sel] + 1'b1;

    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        qcnt_next    = qcnt_reg;
        slice_next   = slice_reg;
        run_next     = run_reg;
        idle_next    = idle_reg;
        bcnt_next    = bcnt_reg;
        task_next    = task_reg;
        cur_next     = cur_reg;
        idx_next     = idx_reg;
        best_ld_next = best_ld_reg;
        rcore_next   = rcore_reg;
        rtask_next   = rtask_reg;
        ridle_next   = ridle_reg;
        rstat_next   = rstat_reg;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_waddr    = {sel, tail_reg[sel]};
        mem_raddr    = {sel, head_reg[sel]};
        mem_wdata    = task_reg;
        bctrl.ins      = 1'b0;
        bctrl.rem      = 1'b0;
        bctrl.idx      = idx_reg[pcrr_pkg::BLK_IDX_W-1:0];
        bctrl.ins_core = sel;
        bctrl.ins_task = run_reg[sel];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    task_next  = task_id;
                    cur_next   = cpu;
                    idx_next   = '0;
                    rcore_next = '0;
                    rtask_next = '0;
                    ridle_next = 1'b0;
                    rstat_next = pcrr_pkg::STAT_OK;
                    case (func)
                        pcrr_pkg::FUNC_LOAD:    state_next = ST_LSCAN;
                        pcrr_pkg::FUNC_UNBLOCK: state_next = ST_SRCH;
                        pcrr_pkg::FUNC_EVENT:   state_next = ST_EVENT;
                        default:                state_next = ST_RESP;
                    endcase
                end
            end
            ST_LSCAN:
            begin
                // One core per cycle through the shared add/compare.
                if (idx_reg == '0 || ld < best_ld_reg)
                begin
                    best_ld_next = ld;
                    cur_next     = sel;
                end
                if (sel == last_core)
                begin
                    state_next = ST_LDEC;
                end
                idx_next = idx_reg + 1'b1;
            end
            ST_LDEC:
            begin
                rcore_next = cur_reg;
                if (q_full)
                begin
                    rstat_next = pcrr_pkg::STAT_QFULL;
                    state_next = ST_RESP;
                end
                else
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                mem_we         = 1'b1;
                tail_next[sel] = tail_reg[sel] + 1'b1;
                qcnt_next[sel] = qcnt_reg[sel] + 1'b1;
                state_next     = ST_RESP;
            end
            ST_SRCH:
            begin
                if (idx_reg == bstat.fill)
                begin
                    rstat_next = pcrr_pkg::STAT_NOT_BLK;
                    state_next = ST_RESP;
                end
                else if (bstat.rd_task == task_reg)
                begin
                    state_next = ST_UCORE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_UCORE:
            begin
                cur_next   = bstat.rd_core;
                state_next = ST_UDEC;
            end
            ST_UDEC:
            begin
                rcore_next = cur_reg;
                if (q_full)
                begin
                    rstat_next = pcrr_pkg::STAT_QFULL;
                    state_next = ST_RESP;
                end
                else
                begin
                    bctrl.rem = 1'b1;
                    if (bcnt_reg[sel] != '0)
                    begin
                        bcnt_next[sel] = bcnt_reg[sel] - 1'b1;
                    end
                    state_next = ST_PUSH;
                end
            end
            ST_EVENT:
            begin
                rcore_next = cur_reg;
                state_next = ST_EVRES;
                case (reason_reg)
                    pcrr_pkg::RSN_EXIT:
                    begin
                        state_next = ST_SWITCH;
                    end
                    pcrr_pkg::RSN_BLOCK:
                    begin
                        if (idle_reg[sel])
                        begin
                            state_next = ST_SWITCH;
                        end
                        else if (bstat.full)
                        begin
                            rstat_next = pcrr_pkg::STAT_BLK_FULL;
                        end
                        else
                        begin
                            bctrl.ins      = 1'b1;
                            bcnt_next[sel] = bcnt_reg[sel] + 1'b1;
                            state_next     = ST_SWITCH;
                        end
                    end
                    pcrr_pkg::RSN_TICK:
                    begin
                        if (idle_reg[sel] && !q_empty)
                        begin
                            state_next = ST_SWITCH;
                        end
                        else if (slice_inc == quant_reg[sel])
                        begin
                            slice_next[sel] = '0;
                            if (!q_empty)
                            begin
                                state_next = ST_ROTRD;
                            end
                        end
                        else
                        begin
                            slice_next[sel] = slice_inc;
                        end
                    end
                    default: ;
                endcase
            end
            ST_SWITCH:
            begin
                if (q_empty)
                begin
                    idle_next[sel] = 1'b1;
                    state_next     = ST_EVRES;
                end
                else
                begin
                    mem_re          = 1'b1;
                    slice_next[sel] = '0;
                    head_next[sel]  = head_reg[sel] + 1'b1;
                    qcnt_next[sel]  = qcnt_reg[sel] - 1'b1;
                    state_next      = ST_POPWAIT;
                end
            end
            ST_POPWAIT:
            begin
                run_next[sel]  = mem_rdata;
                idle_next[sel] = 1'b0;
                state_next     = ST_EVRES;
            end
            ST_ROTRD:
            begin
                mem_re         = 1'b1;
                head_next[sel] = head_reg[sel] + 1'b1;
                state_next     = ST_ROTWAIT;
            end
            ST_ROTWAIT:
            begin
                // Requeue the preempted task behind the others.
                mem_we         = 1'b1;
                mem_wdata      = run_reg[sel];
                tail_next[sel] = tail_reg[sel] + 1'b1;
                run_next[sel]  = mem_rdata;
                state_next     = ST_EVRES;
            end
            ST_EVRES:
            begin
                ridle_next = idle_reg[sel];
                rtask_next = idle_reg[sel] ? '0 : run_reg[sel];
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            for (int i = 0; i < NC; i++)
            begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                qcnt_reg[i]  <= '0;
                slice_reg[i] <= '0;
                idle_reg[i]  <= 1'b1;
                bcnt_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            qcnt_reg  <= qcnt_next;
            slice_reg <= slice_next;
            idle_reg  <= idle_next;
            bcnt_reg  <= bcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_reg     <= run_next;
        task_reg    <= task_next;
        cur_reg     <= cur_next;
        idx_reg     <= idx_next;
        best_ld_reg <= best_ld_next;
        rcore_reg   <= rcore_next;
        rtask_reg   <= rtask_next;
        ridle_reg   <= ridle_next;
        rstat_reg   <= rstat_next;
        if (state_reg == ST_IDLE && start)
        begin
            func_reg   <= func;
            reason_reg <= reason;
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = (state_reg == ST_RESP);
    assign core         = rcore_reg;
    assign next_task    = rtask_reg;
    assign next_is_idle = ridle_reg;
    assign status       = rstat_reg;

    // A result shows for one cycle only, then the block frees itself.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done && !busy)
        else $error("result strobe held or block stuck busy");

    // A taken command makes the block busy on the next cycle.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    // The blocked table never claims more entries than it holds.
    a_blk_fill: assert property (@(posedge clk) disable iff (!rst_n)
        bstat.fill <= pcrr_pkg::BLK_CNT_W'(pcrr_pkg::BLK_DEPTH))
        else $error("blocked table overfilled");

    // Unknown functions return an all-zero result.
    a_unknown_func: assert property (@(posedge clk) disable iff (!rst_n)
        (done && func_reg != pcrr_pkg::FUNC_LOAD && func_reg != pcrr_pkg::FUNC_UNBLOCK
         && func_reg != pcrr_pkg::FUNC_EVENT)
        |-> (core == '0 && next_task == '0 && !next_is_idle && status == '0))
        else $error("unknown function gave a nonzero result");

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for per_core_round_robin_scheduler: directed and random command
// transfers checked against a cycle-free scheduling predictor; needs pcrr_pkg and the RTL.
module tb_top;

    typedef struct packed {
        logic [pcrr_pkg::CORE_W-1:0] core;
        logic [pcrr_pkg::TASK_W-1:0] tsk;
        logic                        idle;
        logic [1:0]                  stat;
    } sched_result_t;

    // Settle time after the last result before touching registers or ending.
    localparam int SETTLE_CYCLES  = 30;
    localparam int WATCHDOG_LIMIT = 5000;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    logic [1:0]                    func = pcrr_pkg::FUNC_LOAD;
    logic [1:0]                    cpu = 2'd0;
    logic [1:0]                    reason = pcrr_pkg::RSN_TICK;
    logic [pcrr_pkg::TASK_W-1:0]   task_id = '0;
    logic                          done;
    logic [pcrr_pkg::CORE_W-1:0]   core;
    logic [pcrr_pkg::TASK_W-1:0]   next_task;
    logic                          next_is_idle;
    logic [1:0]                    status;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [pcrr_pkg::PADDR_W-1:0]  paddr = '0;
    logic [31:0]                   pwdata = '0;
    logic [31:0]                   prdata;
    logic                          pready;

    per_core_round_robin_scheduler dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .func(func), .cpu(cpu), .reason(reason), .task_id(task_id),
        .done(done), .core(core), .next_task(next_task),
        .next_is_idle(next_is_idle), .status(status),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Scheduler predictor: its own copy of configuration and per-core state
    // ---------------------------------------------------------------------
    logic [pcrr_pkg::AC_W-1:0]    cfg_active;
    logic [pcrr_pkg::SLICE_W-1:0] cfg_quantum [pcrr_pkg::MAX_CORES];

    logic [pcrr_pkg::TASK_W-1:0]  rq_slot [pcrr_pkg::MAX_CORES][pcrr_pkg::QUEUE_DEPTH];
    int                           rq_head [pcrr_pkg::MAX_CORES];
    int                           rq_tail [pcrr_pkg::MAX_CORES];
    int                           rq_count [pcrr_pkg::MAX_CORES];
    logic [pcrr_pkg::SLICE_W-1:0] slice_cnt [pcrr_pkg::MAX_CORES];
    logic [pcrr_pkg::TASK_W-1:0]  run_task [pcrr_pkg::MAX_CORES];
    bit                           core_is_idle [pcrr_pkg::MAX_CORES];
    int                           blocked_from [pcrr_pkg::MAX_CORES];
    bit                           bt_valid [pcrr_pkg::BLK_DEPTH];
    logic [pcrr_pkg::CORE_W-1:0]  bt_core [pcrr_pkg::BLK_DEPTH];
    logic [pcrr_pkg::TASK_W-1:0]  bt_task [pcrr_pkg::BLK_DEPTH];

    sched_result_t      pending_results [$];
    bit                 failed = 1'b0;
    int                 idle_pct = 0;
    int                 stall_cycles = 0;

    function automatic void clear_schedule_state();
        cfg_active = 3'd4;
        for (int c = 0; c < pcrr_pkg::MAX_CORES; c++)
        begin
            cfg_quantum[c] = 8'd4;
            rq_head[c] = 0;
            rq_tail[c] = 0;
            rq_count[c] = 0;
            slice_cnt[c] = '0;
            run_task[c] = '0;
            core_is_idle[c] = 1'b1;
            blocked_from[c] = 0;
        end
        for (int i = 0; i < pcrr_pkg::BLK_DEPTH; i++)
            bt_valid[i] = 1'b0;
    endfunction

    function automatic void enqueue_task(int c, logic [pcrr_pkg::TASK_W-1:0] t);
        rq_slot[c][rq_tail[c]] = t;
        rq_tail[c] = (rq_tail[c] + 1) % pcrr_pkg::QUEUE_DEPTH;
        rq_count[c]++;
    endfunction

    function automatic logic [pcrr_pkg::TASK_W-1:0] dequeue_task(int c);
        logic [pcrr_pkg::TASK_W-1:0] t;
        t = rq_slot[c][rq_head[c]];
        rq_head[c] = (rq_head[c] + 1) % pcrr_pkg::QUEUE_DEPTH;
        rq_count[c]--;
        return t;
    endfunction

    // Leave the current task: take the queue head or go idle (slice kept).
    function automatic void dispatch_next(int c);
        if (rq_count[c] == 0)
            core_is_idle[c] = 1'b1;
        else
        begin
            slice_cnt[c] = '0;
            run_task[c] = dequeue_task(c);
            core_is_idle[c] = 1'b0;
        end
    endfunction

    function automatic sched_result_t schedule_outcome(logic [1:0] f, logic [1:0] cp,
                                                       logic [1:0] rs,
                                                       logic [pcrr_pkg::TASK_W-1:0] t);
        sched_result_t r;
        int n, best, best_load, ld, hit, slot, c;
        logic [pcrr_pkg::TASK_W-1:0] nxt;
        r = '0;
        c = cp;
        if (f == pcrr_pkg::FUNC_LOAD)
        begin
            n = cfg_active;
            if (n == 0) n = 1;
            if (n > pcrr_pkg::MAX_CORES) n = pcrr_pkg::MAX_CORES;
            best = 0;
            best_load = 0;
            for (int i = 0; i < n; i++)
            begin
                ld = rq_count[i] + (core_is_idle[i] ? 0 : 1) + blocked_from[i];
                if (i == 0 || ld < best_load)
                begin
                    best_load = ld;
                    best = i;
                end
            end
            r.core = pcrr_pkg::CORE_W'(best);
            if (rq_count[best] >= pcrr_pkg::QUEUE_DEPTH) r.stat = pcrr_pkg::STAT_QFULL;
            else enqueue_task(best, t);
        end
        else if (f == pcrr_pkg::FUNC_UNBLOCK)
        begin
            hit = -1;
            for (int i = 0; i < pcrr_pkg::BLK_DEPTH; i++)
                if (hit < 0 && bt_valid[i] && bt_task[i] == t) hit = i;
            if (hit < 0)
                r.stat = pcrr_pkg::STAT_NOT_BLK;
            else
            begin
                n = bt_core[hit];
                r.core = pcrr_pkg::CORE_W'(n);
                if (rq_count[n] >= pcrr_pkg::QUEUE_DEPTH)
                    r.stat = pcrr_pkg::STAT_QFULL;
                else
                begin
                    // close the gap so entries stay packed in blocking order
                    for (int i = hit; i + 1 < pcrr_pkg::BLK_DEPTH; i++)
                    begin
                        bt_valid[i] = bt_valid[i+1];
                        bt_core[i] = bt_core[i+1];
                        bt_task[i] = bt_task[i+1];
                    end
                    bt_valid[pcrr_pkg::BLK_DEPTH-1] = 1'b0;
                    enqueue_task(n, t);
                    if (blocked_from[n] > 0) blocked_from[n]--;
                end
            end
        end
        else if (f == pcrr_pkg::FUNC_EVENT)
        begin
            r.core = cp;
            if (rs == pcrr_pkg::RSN_EXIT)
                dispatch_next(c);
            else if (rs == pcrr_pkg::RSN_BLOCK)
            begin
                if (core_is_idle[c])
                    dispatch_next(c);
                else
                begin
                    slot = -1;
                    for (int i = 0; i < pcrr_pkg::BLK_DEPTH; i++)
                        if (slot < 0 && !bt_valid[i]) slot = i;
                    if (slot < 0)
                        r.stat = pcrr_pkg::STAT_BLK_FULL;
                    else
                    begin
                        bt_valid[slot] = 1'b1;
                        bt_core[slot] = cp;
                        bt_task[slot] = run_task[c];
                        blocked_from[c]++;
                        dispatch_next(c);
                    end
                end
            end
            else if (rs == pcrr_pkg::RSN_TICK)
            begin
                if (core_is_idle[c] && rq_count[c] != 0)
                    dispatch_next(c);
                else
                begin
                    slice_cnt[c] = slice_cnt[c] + 8'd1;
                    if (slice_cnt[c] == cfg_quantum[c])
                    begin
                        slice_cnt[c] = '0;
                        if (rq_count[c] != 0)
                        begin
                            nxt = dequeue_task(c);
                            enqueue_task(c, run_task[c]);
                            run_task[c] = nxt;
                        end
                    end
                end
            end
            if (core_is_idle[c]) r.idle = 1'b1;
            else r.tsk = run_task[c];
        end
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Result checker: every done strobe must match the oldest expectation
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin
        sched_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no command outstanding: core=%0d task=%0d", core, next_task);
                failed = 1'b1;
            end
            else
            begin
                want = pending_results.pop_front();
                if (core !== want.core)
                begin
                    $error("core: expected %0d, got %0d", want.core, core);
                    failed = 1'b1;
                end
                if (next_task !== want.tsk)
                begin
                    $error("next_task: expected %0d, got %0d", want.tsk, next_task);
                    failed = 1'b1;
                end
                if (next_is_idle !== want.idle)
                begin
                    $error("next_is_idle: expected %0d, got %0d", want.idle, next_is_idle);
                    failed = 1'b1;
                end
                if (status !== want.stat)
                begin
                    $error("status: expected %0d, got %0d", want.stat, status);
                    failed = 1'b1;
                end
            end
        end
    end

    // Watchdog: count cycles with neither a command nor a result transfer.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------------

    // Present one command and hold it until the block takes the transfer.
    // Then drop start for random idle cycles (idle_pct); otherwise start stays high.
    task automatic send_command(logic [1:0] f, logic [1:0] cp, logic [1:0] rs,
                                logic [pcrr_pkg::TASK_W-1:0] t);
        start <= 1'b1;
        func <= f;
        cpu <= cp;
        reason <= rs;
        task_id <= t;
        do @(posedge clk); while (busy);
        pending_results.insert(pending_results.size(), schedule_outcome(f, cp, rs, t));
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Drop start and wait until every expected result is in, then settle.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write: setup then access phase; update the predictor's copy too.
    task automatic write_register(logic [2:0] idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= pcrr_pkg::PADDR_W'(idx) << 2;
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        if (idx == pcrr_pkg::REG_ACTIVE) cfg_active = val[pcrr_pkg::AC_W-1:0];
        else cfg_quantum[idx - pcrr_pkg::REG_QUANT0] = val[pcrr_pkg::SLICE_W-1:0];
    endtask

    task automatic configure(logic [2:0] act, logic [7:0] q0, logic [7:0] q1,
                             logic [7:0] q2, logic [7:0] q3);
        write_register(pcrr_pkg::REG_ACTIVE, 32'(act));
        write_register(pcrr_pkg::REG_QUANT0, 32'(q0));
        write_register(pcrr_pkg::REG_QUANT1, 32'(q1));
        write_register(pcrr_pkg::REG_QUANT2, 32'(q2));
        write_register(pcrr_pkg::REG_QUANT3, 32'(q3));
    endtask

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Every operation, extremes of the ids, idle-core and unknown-code cases.
    task automatic test_basic_operations();
        send_command(pcrr_pkg::FUNC_LOAD, 2'd0, pcrr_pkg::RSN_TICK, 8'h00);
        send_command(pcrr_pkg::FUNC_LOAD, 2'd3, pcrr_pkg::RSN_EXIT, 8'hFF);
        send_command(pcrr_pkg::FUNC_LOAD, 2'd1, pcrr_pkg::RSN_BLOCK, 8'h5A);
        send_command(pcrr_pkg::FUNC_LOAD, 2'd2, 2'd3, 8'hA5);
        // idle core picks up its queue
        send_command(pcrr_pkg::FUNC_EVENT, 2'd0, pcrr_pkg::RSN_TICK, 8'h00);
        // exit on an idle core
        send_command(pcrr_pkg::FUNC_EVENT, 2'd1, pcrr_pkg::RSN_EXIT, 8'h00);
        // running task blocks
        send_command(pcrr_pkg::FUNC_EVENT, 2'd0, pcrr_pkg::RSN_BLOCK, 8'h00);
        // blocked task weighs on core 0
        send_command(pcrr_pkg::FUNC_LOAD, 2'd0, pcrr_pkg::RSN_TICK, 8'h33);
        send_command(pcrr_pkg::FUNC_UNBLOCK, 2'd0, pcrr_pkg::RSN_TICK, 8'h00);
        // never blocked
        send_command(pcrr_pkg::FUNC_UNBLOCK, 2'd2, pcrr_pkg::RSN_TICK, 8'h77);
        // block on an idle core acts as exit
        send_command(pcrr_pkg::FUNC_EVENT, 2'd3, pcrr_pkg::RSN_BLOCK, 8'h00);
        // queue empty: go idle
        send_command(pcrr_pkg::FUNC_EVENT, 2'd3, pcrr_pkg::RSN_EXIT, 8'h00);
        // idle and empty: counter still runs
        send_command(pcrr_pkg::FUNC_EVENT, 2'd3, pcrr_pkg::RSN_TICK, 8'h00);
        // unknown reason
        send_command(pcrr_pkg::FUNC_EVENT, 2'd1, 2'd3, 8'hFF);
        // unknown func
        send_command(2'd3, 2'd2, pcrr_pkg::RSN_EXIT, 8'hC3);
        repeat (5) send_command(pcrr_pkg::FUNC_EVENT, 2'd1, pcrr_pkg::RSN_TICK, 8'h00);
        send_command(pcrr_pkg::FUNC_EVENT, 2'd0, pcrr_pkg::RSN_TICK, 8'h00);
        drain_results();
    endtask

    // One core: fill the blocked table past full, then the ready queue, then
    // unblock into a full queue.
    task automatic test_full_tables();
        configure(3'd1, 8'd255, 8'd1, 8'd1, 8'd1);
        for (int i = 0; i < pcrr_pkg::BLK_DEPTH + 1; i++)
        begin
            send_command(pcrr_pkg::FUNC_LOAD, 2'd0, pcrr_pkg::RSN_TICK, 8'(8'h80 + i));
            send_command(pcrr_pkg::FUNC_EVENT, 2'd0, pcrr_pkg::RSN_TICK, 8'h00);
            send_command(pcrr_pkg::FUNC_EVENT, 2'd0, pcrr_pkg::RSN_BLOCK, 8'h00);
        end
        for (int i = 0; i < pcrr_pkg::BLK_DEPTH - 1; i++)
            send_command(pcrr_pkg::FUNC_UNBLOCK, 2'd0, pcrr_pkg::RSN_TICK, 8'(8'h80 + i));
        send_command(pcrr_pkg::FUNC_LOAD, 2'd0, pcrr_pkg::RSN_TICK, 8'h11);
        send_command(pcrr_pkg::FUNC_LOAD, 2'd0, pcrr_pkg::RSN_TICK, 8'h22);
        send_command(pcrr_pkg::FUNC_UNBLOCK, 2'd0, pcrr_pkg::RSN_TICK, 8'h8F);
        for (int i = 0; i < 20; i++)
            send_command(pcrr_pkg::FUNC_EVENT, 2'd0, pcrr_pkg::RSN_EXIT, 8'h00);
        drain_results();
    endtask

    // Random mix, weighted toward sequences that keep queues and the blocked
    // table busy, with some noise in the codes.
    task automatic test_random_traffic(int count);
        int roll, queued, live, pick;
        logic [pcrr_pkg::TASK_W-1:0] t;
        for (int k = 0; k < count; k++)
        begin
            queued = 0;
            live = 0;
            for (int c = 0; c < pcrr_pkg::MAX_CORES; c++) queued += rq_count[c];
            for (int i = 0; i < pcrr_pkg::BLK_DEPTH; i++) live += bt_valid[i];
            roll = $urandom_range(99);
            t = 8'($urandom_range(255));
            if (roll < (queued < 30 ? 32 : 12))
                send_command(pcrr_pkg::FUNC_LOAD, 2'($urandom_range(3)),
                             2'($urandom_range(3)), t);
            else if (roll < 50)
            begin
                if (live != 0 && $urandom_range(9) < 8)
                begin
                    pick = $urandom_range(live - 1);
                    t = bt_task[pick];
                end
                send_command(pcrr_pkg::FUNC_UNBLOCK, 2'($urandom_range(3)),
                             2'($urandom_range(3)), t);
            end
            else if (roll < 96)
            begin
                pick = $urandom_range(99);
                send_command(pcrr_pkg::FUNC_EVENT, 2'($urandom_range(3)),
                             pick < 50 ? pcrr_pkg::RSN_TICK : pick < 75 ? pcrr_pkg::RSN_BLOCK :
                             pick < 96 ? pcrr_pkg::RSN_EXIT : 2'd3, t);
            end
            else
                send_command(2'd3, 2'($urandom_range(3)), 2'($urandom_range(3)), t);
            // Hold off once until everything outstanding has come back.
            if (k == count / 2) drain_results();
        end
        drain_results();
    endtask

    initial
    begin
        clear_schedule_state();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_pct = 35;
        test_basic_operations();
        test_full_tables();
        configure(3'd4, 8'd1, 8'd255, 8'd2, 8'd3);
        test_random_traffic(230);
        configure(3'd0, 8'd0, 8'd5, 8'd1, 8'd255);
        test_random_traffic(230);

        idle_pct = 47;
        configure(3'd7, 8'd255, 8'd255, 8'd255, 8'd255);
        test_random_traffic(230);
        configure(3'd2, 8'd3, 8'd0, 8'd7, 8'd1);
        test_random_traffic(230);

        idle_pct = 0;
        configure(3'd3, 8'd2, 8'd1, 8'd4, 8'd6);
        test_random_traffic(230);
        configure(3'd5, 8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(3)), 8'($urandom_range(1, 4)));
        test_random_traffic(230);

        if (!failed)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
